>>> rtl/monotone_polygon_triangulator_macros.svh
// ---------------------------------------------------------------------------
// Monotone polygon triangulator assertion macros
// Shorthand for the concurrent checks of the triangulator checker.
// ---------------------------------------------------------------------------
`ifndef MONOTONE_POLYGON_TRIANGULATOR_MACROS_SVH
`define MONOTONE_POLYGON_TRIANGULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mpt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Monotone polygon triangulator package
// Word types, vertex record and shared constants of the triangulator.
// ---------------------------------------------------------------------------
package mpt_pkg;

    localparam int COORD_W          = 16;
    localparam int IDX_W            = 6;
    localparam int MAX_VERTICES_DEF = 64;

    // One vertex word on the input channel.
    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      chain_right;
        logic                      first_vertex;
        logic                      last_vertex;
    } t_vertex_in;

    // One diagonal word on the output channel.
    typedef struct packed {
        logic [IDX_W-1:0] from_index;
        logic [IDX_W-1:0] to_index;
        logic             overflow;
        logic             run_end;
    } t_diag_out;

    // Stack entry: coordinates and arrival index.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IDX_W-1:0]          idx;
    } t_vtx;

    // Status of the orientation unit.
    typedef struct packed {
        logic done;
        logic pass;
    } t_orient_res;

endpackage

>>> rtl/mpt_orient.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Orientation test unit
// Three-stage pipeline: edge differences, cross products, sign decision.
// ---------------------------------------------------------------------------
module mpt_orient import mpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_vtx        i_u,
    input  t_vtx        i_v,
    input  t_vtx        i_w,
    input  logic        i_chain_right,
    output t_orient_res o_res
);

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;

    logic                     r_s1_valid;
    logic                     r_s2_valid;
    logic                     r_done;
    logic                     r_pass;
    logic                     r_chain1;
    logic                     r_chain2;
    logic signed [DIFF_W-1:0] r_ax;
    logic signed [DIFF_W-1:0] r_ay;
    logic signed [DIFF_W-1:0] r_bx;
    logic signed [DIFF_W-1:0] r_by;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic [PROD_W:0]          cross_val;
    logic                     cross_neg;
    logic                     cross_zero;
    logic                     keep;

    // The products cannot overflow one extra bit, so the sign bit is exact.
    assign cross_val  = {r_p1[PROD_W-1], r_p1} - {r_p2[PROD_W-1], r_p2};
    assign cross_neg  = cross_val[PROD_W];
    assign cross_zero = (cross_val == '0);
    assign keep       = !((cross_neg && r_chain2) ||
                          (!cross_neg && !cross_zero && !r_chain2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
            r_s2_valid <= r_s1_valid;
            r_done     <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ax     <= $signed({i_v.x[COORD_W-1], i_v.x}) - $signed({i_u.x[COORD_W-1], i_u.x});
            r_ay     <= $signed({i_v.y[COORD_W-1], i_v.y}) - $signed({i_u.y[COORD_W-1], i_u.y});
            r_bx     <= $signed({i_w.x[COORD_W-1], i_w.x}) - $signed({i_u.x[COORD_W-1], i_u.x});
            r_by     <= $signed({i_w.y[COORD_W-1], i_w.y}) - $signed({i_u.y[COORD_W-1], i_u.y});
            r_chain1 <= i_chain_right;
        end
        if (r_s1_valid) begin
            r_p1     <= r_ax * r_by;
            r_p2     <= r_ay * r_bx;
            r_chain2 <= r_chain1;
        end
        if (r_s2_valid) begin
            r_pass <= keep;
        end
    end

    assign o_res.done = r_done;
    assign o_res.pass = r_pass;

endmodule

>>> rtl/monotone_polygon_triangulator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Monotone polygon triangulator
// Stack pass of y-monotone triangulation; emits diagonals as index pairs.
// ---------------------------------------------------------------------------
// Vertices arrive top to bottom, one word each, and are numbered in arrival
// order. The vertex stack lives in a single-port-read, single-port-write
// memory with registered read data, and one vertex is worked on at a time.
// A vertex on the opposite chain and a last vertex emit their diagonals one
// per stack read. A vertex on the same chain runs orientation tests, each
// waiting on the memory read and the three-stage cross product unit.
// Output back pressure can hold the walk. The next vertex is taken while
// the last diagonal word still waits in the output register.
module monotone_polygon_triangulator import mpt_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_vertex_in i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_diag_out  o_out_word
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_OVF,
        S_OPP,
        S_LAST,
        S_SV,
        S_SW,
        S_SWAIT,
        S_SDEC,
        S_PUSHV,
        S_PUSHU,
        S_FLUSH
    } t_state;

    t_state           r_state;
    logic [DW-1:0]    r_count;
    logic [DW-1:0]    r_depth;
    logic [DW-1:0]    r_ptr;
    logic             r_chain;
    logic             r_in_chain;
    logic             r_push_prev;
    t_vtx             r_prev;
    t_vtx             r_u;
    t_vtx             r_v;
    logic             r_pend_valid;
    logic [IDX_W-1:0] r_pend_to;
    logic             r_out_valid;
    t_diag_out        r_out;

    t_vtx             r_mem [MAX_VERTICES];
    t_vtx             r_rd;

    logic             accept;
    logic [DW-1:0]    cnt_eff;
    logic [DW-1:0]    dep_eff;
    logic [DW-1:0]    dep_m1;
    logic [DW-1:0]    ptr_m1;
    logic [DW-1:0]    ptr_p1;
    logic [DW-1:0]    depth_m1;
    logic [DW-1:0]    depth_m2;
    logic             in_ovf;
    t_vtx             in_vtx;
    logic             out_free;
    logic             emit_ok;
    logic             emit_req;
    logic             emit_go;
    logic [IDX_W-1:0] emit_to;
    logic             out_load;
    t_diag_out        out_data;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_vtx             mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             orient_start;
    t_orient_res      orient_res;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign accept   = i_in_valid && !o_in_stall;
    assign cnt_eff  = i_in_word.first_vertex ? '0 : r_count;
    assign dep_eff  = i_in_word.first_vertex ? '0 : r_depth;
    assign dep_m1   = dep_eff - DW'(1);
    assign ptr_m1   = r_ptr - DW'(1);
    assign ptr_p1   = r_ptr + DW'(1);
    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);
    assign in_ovf   = (cnt_eff >= DW'(MAX_VERTICES));

    assign in_vtx.x   = i_in_word.vertex_x;
    assign in_vtx.y   = i_in_word.vertex_y;
    assign in_vtx.idx = IDX_W'(cnt_eff);

    // A diagonal is held back in a pending register so that run_end can be set on the
    // final word of a vertex once the walk is known to be over.
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit_ok  = !r_pend_valid || out_free;

    always_comb begin
        emit_req = 1'b0;
        emit_to  = r_rd.idx;
        case (r_state)
            S_OPP, S_LAST: emit_req = 1'b1;
            S_SDEC:        emit_req = orient_res.pass;
            default:       emit_req = 1'b0;
        endcase
        emit_go = emit_req && emit_ok;
    end

    always_comb begin
        out_load            = 1'b0;
        out_data.from_index = r_u.idx;
        out_data.to_index   = r_pend_to;
        out_data.overflow   = 1'b0;
        out_data.run_end    = 1'b0;
        case (r_state)
            S_OVF: begin
                out_load            = out_free;
                out_data.from_index = '0;
                out_data.to_index   = '0;
                out_data.overflow   = 1'b1;
                out_data.run_end    = 1'b1;
            end
            S_FLUSH: begin
                out_load         = r_pend_valid && out_free;
                out_data.run_end = 1'b1;
            end
            default: begin
                out_load = emit_go && r_pend_valid;
            end
        endcase
    end

    // Stack memory port control.
    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = r_depth[AW-1:0];
        mem_wdata    = r_u;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        orient_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && !in_ovf) begin
                    if (i_in_word.last_vertex) begin
                        if (cnt_eff >= DW'(2) && dep_eff >= DW'(3)) begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(1);
                        end
                    end else if (cnt_eff == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = in_vtx;
                    end else if (cnt_eff == DW'(1)) begin
                        mem_we    = (dep_eff < DW'(MAX_VERTICES));
                        mem_waddr = dep_eff[AW-1:0];
                        mem_wdata = in_vtx;
                    end else if (dep_eff >= DW'(2)) begin
                        mem_re    = 1'b1;
                        mem_raddr = dep_m1[AW-1:0];
                    end
                end
            end
            S_OPP: begin
                if (emit_ok && r_ptr > DW'(1)) begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_m1[AW-1:0];
                end
            end
            S_LAST: begin
                if (emit_ok && r_ptr != depth_m2) begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_p1[AW-1:0];
                end
            end
            S_SV: begin
                if (r_depth >= DW'(2)) begin
                    mem_re    = 1'b1;
                    mem_raddr = depth_m1[AW-1:0];
                end
            end
            S_SW: begin
                orient_start = 1'b1;
            end
            S_SDEC: begin
                if (emit_go && depth_m1 >= DW'(2)) begin
                    mem_re    = 1'b1;
                    mem_raddr = depth_m2[AW-1:0];
                end
            end
            S_PUSHV: begin
                mem_we    = r_push_prev && (r_depth < DW'(MAX_VERTICES));
                mem_wdata = r_prev;
            end
            S_PUSHU: begin
                mem_we = (r_depth < DW'(MAX_VERTICES));
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    mpt_orient u_orient (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (orient_start),
        .i_u          (r_u),
        .i_v          (r_v),
        .i_w          (r_rd),
        .i_chain_right(r_in_chain),
        .o_res        (orient_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_depth      <= '0;
            r_chain      <= 1'b0;
            r_prev       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= out_data;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (emit_go) begin
                r_pend_valid <= 1'b1;
                r_pend_to    <= emit_to;
            end else if (r_state == S_FLUSH && out_free) begin
                r_pend_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_u        <= in_vtx;
                        r_in_chain <= i_in_word.chain_right;
                        if (in_ovf) begin
                            r_state <= S_OVF;
                            r_count <= i_in_word.last_vertex ? '0 : cnt_eff;
                            r_depth <= i_in_word.last_vertex ? '0 : dep_eff;
                        end else begin
                            r_count <= i_in_word.last_vertex ? '0 : cnt_eff + DW'(1);
                            if (i_in_word.last_vertex) begin
                                if (cnt_eff >= DW'(2) && dep_eff >= DW'(3)) begin
                                    r_ptr   <= DW'(1);
                                    r_depth <= dep_eff;
                                    r_state <= S_LAST;
                                end else begin
                                    r_depth <= '0;
                                    r_prev  <= in_vtx;
                                end
                            end else if (cnt_eff == '0) begin
                                r_depth <= DW'(1);
                                r_prev  <= in_vtx;
                            end else if (cnt_eff == DW'(1)) begin
                                if (dep_eff < DW'(MAX_VERTICES)) begin
                                    r_depth <= dep_eff + DW'(1);
                                end else begin
                                    r_depth <= dep_eff;
                                end
                                r_chain <= i_in_word.chain_right;
                                r_prev  <= in_vtx;
                            end else if (dep_eff < DW'(2)) begin
                                // Short stack: the previous vertex goes in
                                // first when the stack is empty.
                                r_depth     <= dep_eff;
                                r_push_prev <= (dep_eff == '0);
                                r_state     <= (dep_eff == '0) ? S_PUSHV : S_PUSHU;
                            end else if (i_in_word.chain_right != r_chain) begin
                                r_ptr   <= dep_m1;
                                r_state <= S_OPP;
                            end else begin
                                r_depth <= dep_m1;
                                r_state <= S_SV;
                            end
                        end
                    end
                end
                S_OVF: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_OPP: begin
                    if (emit_go) begin
                        if (r_ptr == DW'(1)) begin
                            r_depth     <= '0;
                            r_push_prev <= 1'b1;
                            r_state     <= S_PUSHV;
                        end else begin
                            r_ptr <= ptr_m1;
                        end
                    end
                end
                S_LAST: begin
                    if (emit_go) begin
                        if (r_ptr == depth_m2) begin
                            r_depth <= '0;
                            r_state <= S_FLUSH;
                        end else begin
                            r_ptr <= ptr_p1;
                        end
                    end
                end
                S_SV: begin
                    r_v <= r_rd;
                    if (r_depth >= DW'(2)) begin
                        r_state <= S_SW;
                    end else begin
                        r_push_prev <= 1'b0;
                        r_state     <= S_PUSHV;
                    end
                end
                S_SW: begin
                    r_state <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (orient_res.done) begin
                        r_state <= S_SDEC;
                    end
                end
                S_SDEC: begin
                    if (!orient_res.pass) begin
                        r_push_prev <= 1'b0;
                        r_state     <= S_PUSHV;
                    end else if (emit_go) begin
                        // The tested entry becomes the new top candidate.
                        r_depth <= depth_m1;
                        r_v     <= r_rd;
                        if (depth_m1 >= DW'(2)) begin
                            r_state <= S_SW;
                        end else begin
                            r_push_prev <= 1'b0;
                            r_state     <= S_PUSHV;
                        end
                    end
                end
                S_PUSHV: begin
                    // On the same chain the kept vertex already sits at the
                    // top slot, so only the depth moves.
                    if (r_depth < DW'(MAX_VERTICES)) begin
                        r_depth <= r_depth + DW'(1);
                    end
                    r_state <= S_PUSHU;
                end
                S_PUSHU: begin
                    if (r_depth < DW'(MAX_VERTICES)) begin
                        r_depth <= r_depth + DW'(1);
                    end
                    r_chain <= r_in_chain;
                    r_state <= S_FLUSH;
                end
                S_FLUSH: begin
                    r_prev <= r_u;
                    if (!r_pend_valid || out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/mpt_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Monotone polygon triangulator checker
// Port-level checks on the diagonal words, bound to the top level.
// ---------------------------------------------------------------------------
`include "monotone_polygon_triangulator_macros.svh"

module mpt_checker import mpt_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_diag_out  o_out_word
);

    logic out_held;
    logic ovf_seen;
    logic ovf_ok;
    logic diag_seen;
    logic diag_back;

    assign out_held  = o_out_valid && i_out_stall;
    assign ovf_seen  = o_out_valid && o_out_word.overflow;
    assign ovf_ok    = o_out_word.run_end && (o_out_word.from_index == '0)
                       && (o_out_word.to_index == '0);
    assign diag_seen = o_out_valid && !o_out_word.overflow;
    assign diag_back = (o_out_word.to_index < o_out_word.from_index);

    // A stalled word stays put.
    `MPT_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(o_out_word), "stalled word changed")

    // An overflow word carries no diagonal and closes its vertex.
    `MPT_ASSERT_SAME(a_ovf_word, ovf_seen, ovf_ok, "malformed overflow word")

    // A diagonal always reaches back to an earlier vertex.
    `MPT_ASSERT_SAME(a_diag_order, diag_seen, diag_back, "diagonal points forward")

    // New words come only out of a busy sequencer.
    `MPT_ASSERT_SAME(a_word_from_busy, $rose(o_out_valid), $past(o_in_stall), "word while idle")

endmodule

bind monotone_polygon_triangulator mpt_checker u_mpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_word (o_out_word)
);
